// ===== hw/rtl/akel_pkg.sv =====
// types, constants and rotate helpers shared by the cipher datapath
`default_nettype none
package akel_pkg;
   localparam int WordWidth = 32;
   localparam int IndexWidth = 6;
   localparam int RotWidth = 7;
   localparam logic KindLoad = 1'b0;
   localparam logic KindBlock = 1'b1;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      word_type w0;
      word_type w1;
      word_type w2;
      word_type w3;
   } block_type;

   // upper 31 bits rotate, bit 0 kept; shifted field may leak into bit 0
   function automatic word_type rot_hi31(input word_type v, input logic [4:0] n);
      word_type f;
      word_type lo;
      f = v & 32'hffff_fffe;
      lo = f >> (5'd31 - n);
      return (f << n) | lo | (v & 32'h0000_0001);
   endfunction

   // lower 31 bits rotate, bit 31 kept; shifted field may leak into bit 31
   function automatic word_type rot_lo31(input word_type v, input logic [4:0] n);
      word_type f;
      word_type lo;
      f = v & 32'h7fff_ffff;
      lo = f >> (5'd31 - n);
      return (f << n) | lo | (v & 32'h8000_0000);
   endfunction

   function automatic block_type rot128(input block_type b, input logic [RotWidth-1:0] amt);
      logic [127:0] v;
      logic [255:0] d;
      v = {b.w3, b.w2, b.w1, b.w0};
      d = {v, v} << amt;
      return block_type'({d[159:128], d[191:160], d[223:192], d[255:224]});
   endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/akel_if.sv =====
// valid/ready channel carrying one beat of payload
`default_nettype none
interface akel_if #(parameter type payload_type = logic) (input wire logic clock);
   logic valid;
   logic ready;
   payload_type data;
   modport source(output valid, output data, input ready);
   modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/akel_round.sv =====
// one cipher round split over three register stages
`default_nettype none
module akel_round
   import akel_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      advance,
   input  wire logic      in_valid,
   input  wire block_type in_block,
   input  wire word_type  key [13],
   output logic           out_valid,
   output block_type      out_block
);
   block_type  x_in, x1_ff, x2_ff, x3_ff;
   word_type   t1_in, t2_in, t1a_ff, t2a_ff, t2b_ff, t1b_ff;
   logic [2:0] v_ff;
   word_type   t2, t1;
   word_type   t2_in_s2;
   block_type  xo;

   // stage 1: key rotate and first half of the t2 chain
   always_comb begin
      x_in = rot128(in_block, key[0][RotWidth-1:0]);
      t1_in = x_in.w0 ^ x_in.w2;
      t2 = x_in.w1 ^ x_in.w3;
      t2 = rot_hi31(t2, t1_in[4:0]) + key[1];
      t2 = rot_lo31(t2, t1_in[9:5]) + key[2];
      t2 = rot_hi31(t2, t1_in[14:10]) + key[3];
      t2 = rot_lo31(t2, t1_in[19:15]) + key[4];
      t2_in = t2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (advance) begin
         v_ff <= {v_ff[1:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x1_ff <= x_in;
         t1a_ff <= t1_in;
         t2a_ff <= t2_in;
         x2_ff <= x1_ff;
         t1b_ff <= t1;
         t2b_ff <= t2_in_s2;
         x3_ff <= xo;
      end
   end

   // stage 2: rest of the t2 chain, start of the t1 chain
   always_comb begin
      t2_in_s2 = rot_hi31(t2a_ff, {1'b0, t1a_ff[23:20]}) + key[5];
      t2_in_s2 = rot_lo31(t2_in_s2, {1'b0, t1a_ff[27:24]}) + key[6];
      t2_in_s2 = rot_hi31(t2_in_s2, {1'b0, t1a_ff[31:28]});
      t1 = rot_lo31(t1a_ff, t2_in_s2[4:0]) + key[7];
      t1 = rot_hi31(t1, t2_in_s2[9:5]) + key[8];
   end

   // stage 3: end of the t1 chain and mixing
   always_comb begin
      word_type u;
      u = rot_lo31(t1b_ff, t2b_ff[14:10]) + key[9];
      u = rot_hi31(u, t2b_ff[19:15]) + key[10];
      u = rot_lo31(u, {1'b0, t2b_ff[23:20]}) + key[11];
      u = rot_hi31(u, {1'b0, t2b_ff[27:24]}) + key[12];
      u = rot_lo31(u, {1'b0, t2b_ff[31:28]});
      xo.w0 = x2_ff.w0 ^ t2b_ff;
      xo.w2 = x2_ff.w2 ^ t2b_ff;
      xo.w1 = x2_ff.w1 ^ u;
      xo.w3 = x2_ff.w3 ^ u;
   end

   assign out_valid = v_ff[2];
   assign out_block = x3_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/akelarre_block_cipher.sv =====
// 128-bit akelarre cipher engine: subkey store, round pipeline, output register
// throughput: one block beat per cycle while the output register is not stalled
// a subkey load waits until no block is in flight
// a full output register stalls the whole pipeline, nothing is dropped
// reset clears valid bits and the in-flight count only; subkey registers are undefined until loaded
`default_nettype none
module akelarre_block_cipher
   import akel_pkg::*;
#(
   parameter int ROUND_COUNT = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic req_kind,
   input  wire logic [IndexWidth-1:0] req_key_index,
   input  wire logic [WordWidth-1:0] req_key_word,
   input  wire logic [WordWidth-1:0] req_word0,
   input  wire logic [WordWidth-1:0] req_word1,
   input  wire logic [WordWidth-1:0] req_word2,
   input  wire logic [WordWidth-1:0] req_word3,
   input  wire logic req_valid,
   output logic      req_ready,
   output logic [WordWidth-1:0] rsp_out0,
   output logic [WordWidth-1:0] rsp_out1,
   output logic [WordWidth-1:0] rsp_out2,
   output logic [WordWidth-1:0] rsp_out3,
   output logic      rsp_valid,
   input  wire logic rsp_ready
);
   localparam int SubkeyCount = 13 * ROUND_COUNT + 9;

   akel_if #(.payload_type(block_type)) out_ch (.clock(clock));

   // subkeys held in flip-flops, each read at a fixed place
   word_type  subkey_ff [SubkeyCount];
   logic      advance;
   logic      v_ff, rv_ff;
   block_type b_ff, rb_ff;
   block_type rb [ROUND_COUNT+1];
   logic      rv [ROUND_COUNT+1];
   block_type fin;
   logic [7:0] flight_ff, flight_in;
   logic      take_block, drop_block;

   assign advance = !rv_ff || out_ch.ready;
   // a load must not change subkeys that a block in flight still reads
   assign req_ready = advance && (req_kind == KindBlock || flight_ff == '0);

   assign take_block = req_valid && req_ready && req_kind == KindBlock;
   assign drop_block = advance && rv[ROUND_COUNT];
   assign flight_in = flight_ff + {7'b0, take_block} - {7'b0, drop_block};

   always_ff @(posedge clock) begin
      if (req_valid && req_ready && req_kind == KindLoad
          && req_key_index < IndexWidth'(SubkeyCount)) begin
         subkey_ff[req_key_index] <= req_key_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flight_ff <= '0;
      end else begin
         flight_ff <= flight_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else if (advance) begin
         v_ff <= req_valid && req_kind == KindBlock;
         rv_ff <= rv[ROUND_COUNT];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         b_ff.w0 <= req_word0 + subkey_ff[0];
         b_ff.w1 <= req_word1 ^ subkey_ff[1];
         b_ff.w2 <= req_word2 ^ subkey_ff[2];
         b_ff.w3 <= req_word3 + subkey_ff[3];
         rb_ff <= fin;
      end
   end

   assign rb[0] = b_ff;
   assign rv[0] = v_ff;

   for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
      word_type k [13];
      for (genvar j = 0; j < 13; j++) begin : g_key
         assign k[j] = subkey_ff[4 + 13 * g + j];
      end
      akel_round u_round (
         .clock(clock), .reset(reset), .advance(advance),
         .in_valid(rv[g]), .in_block(rb[g]), .key(k),
         .out_valid(rv[g+1]), .out_block(rb[g+1])
      );
   end

   always_comb begin
      block_type r;
      r = rot128(rb[ROUND_COUNT], subkey_ff[SubkeyCount-5][RotWidth-1:0]);
      fin.w0 = r.w0 + subkey_ff[SubkeyCount-4];
      fin.w1 = r.w1 ^ subkey_ff[SubkeyCount-3];
      fin.w2 = r.w2 ^ subkey_ff[SubkeyCount-2];
      fin.w3 = r.w3 + subkey_ff[SubkeyCount-1];
   end

   assign out_ch.valid = rv_ff;
   assign out_ch.data = rb_ff;
   assign out_ch.ready = rsp_ready;
   assign rsp_valid = out_ch.valid;
   assign rsp_out0 = out_ch.data.w0;
   assign rsp_out1 = out_ch.data.w1;
   assign rsp_out2 = out_ch.data.w2;
   assign rsp_out3 = out_ch.data.w3;
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// self-checking testbench for the akelarre cipher engine: subkey loads, block beats, stalls
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
   import akel_pkg::*;

   localparam int RoundCount = 4;
   localparam int SubkeyCount = 13 * RoundCount + 9;
   localparam int Latency = 3 * RoundCount + 2;
   localparam int CycleLimit = 400000;

   typedef struct packed {
      logic kind;
      logic [IndexWidth-1:0] key_index;
      word_type key_word;
      block_type blk;
   } cmd_type;

   typedef struct {
      logic hold;
      cmd_type cmd;
   } pend_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   akel_if #(.payload_type(cmd_type)) req_ch (clock);
   akel_if #(.payload_type(block_type)) rsp_ch (clock);

   akelarre_block_cipher #(.ROUND_COUNT(RoundCount)) dut (
      .clock(clock),
      .reset(reset),
      .req_kind(req_ch.data.kind),
      .req_key_index(req_ch.data.key_index),
      .req_key_word(req_ch.data.key_word),
      .req_word0(req_ch.data.blk.w0),
      .req_word1(req_ch.data.blk.w1),
      .req_word2(req_ch.data.blk.w2),
      .req_word3(req_ch.data.blk.w3),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .rsp_out0(rsp_ch.data.w0),
      .rsp_out1(rsp_ch.data.w1),
      .rsp_out2(rsp_ch.data.w2),
      .rsp_out3(rsp_ch.data.w3),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready)
   );

   word_type subkey_copy [SubkeyCount];
   pend_type pending_q [$];
   block_type cipher_q [$];
   int errors = 0;
   int cycles = 0;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.data = '0;
      rsp_ch.ready = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic word_type spin_upper(input word_type v, input word_type s);
      word_type f;
      logic [4:0] n;
      f = v & 32'hffff_fffe;
      n = s[4:0];
      return (f << n) | (f >> (31 - n)) | (v & 32'h1);
   endfunction

   function automatic word_type spin_lower(input word_type v, input word_type s);
      word_type f;
      logic [4:0] n;
      f = v & 32'h7fff_ffff;
      n = s[4:0];
      return (f << n) | (f >> (31 - n)) | (v & 32'h8000_0000);
   endfunction

   // word 3 is the most significant
   function automatic logic [127:0] turn128(input logic [127:0] v, input logic [6:0] a);
      if (a == 0) begin
         return v;
      end
      return (v << a) | (v >> (128 - a));
   endfunction

   function automatic block_type encipher(input block_type b);
      word_type x0, x1, x2, x3, t1, t2, amt;
      logic [127:0] v;
      int k;
      int offs [7];
      block_type res;
      offs = '{0, 5, 10, 15, 20, 24, 28};
      x0 = b.w0 + subkey_copy[0];
      x1 = b.w1 ^ subkey_copy[1];
      x2 = b.w2 ^ subkey_copy[2];
      x3 = b.w3 + subkey_copy[3];
      k = 4;
      for (int r = 0; r < RoundCount; r++) begin
         v = turn128({x3, x2, x1, x0}, subkey_copy[k][6:0]);
         k++;
         {x3, x2, x1, x0} = v;
         t1 = x0 ^ x2;
         t2 = x1 ^ x3;
         for (int j = 0; j < 7; j++) begin
            amt = t1 >> offs[j];
            if (j >= 4) amt = amt & 32'hf;
            t2 = (j % 2 == 0) ? spin_upper(t2, amt) : spin_lower(t2, amt);
            if (j < 6) begin
               t2 = t2 + subkey_copy[k];
               k++;
            end
         end
         for (int j = 0; j < 7; j++) begin
            amt = t2 >> offs[j];
            if (j >= 4) amt = amt & 32'hf;
            t1 = (j % 2 == 0) ? spin_lower(t1, amt) : spin_upper(t1, amt);
            if (j < 6) begin
               t1 = t1 + subkey_copy[k];
               k++;
            end
         end
         x0 = x0 ^ t2;
         x2 = x2 ^ t2;
         x1 = x1 ^ t1;
         x3 = x3 ^ t1;
      end
      v = turn128({x3, x2, x1, x0}, subkey_copy[k][6:0]);
      k++;
      {x3, x2, x1, x0} = v;
      res.w0 = x0 + subkey_copy[k];
      res.w1 = x1 ^ subkey_copy[k+1];
      res.w2 = x2 ^ subkey_copy[k+2];
      res.w3 = x3 + subkey_copy[k+3];
      return res;
   endfunction

   function automatic void add_load(input int idx, input word_type val);
      pend_type p;
      p.hold = 1'b0;
      p.cmd = '0;
      p.cmd.kind = KindLoad;
      p.cmd.key_index = idx[IndexWidth-1:0];
      p.cmd.key_word = val;
      p.cmd.blk = {$urandom, $urandom, $urandom, $urandom};
      pending_q.push_back(p);
   endfunction

   function automatic void add_block(input block_type b);
      pend_type p;
      p.hold = 1'b0;
      p.cmd.kind = KindBlock;
      p.cmd.key_index = IndexWidth'($urandom);
      p.cmd.key_word = $urandom;
      p.cmd.blk = b;
      pending_q.push_back(p);
   endfunction

   function automatic void add_hold();
      pend_type p;
      p.hold = 1'b1;
      p.cmd = '0;
      pending_q.push_back(p);
   endfunction

   function automatic word_type rand_word();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return '1;
         default: return $urandom;
      endcase
   endfunction

   // sender: bursts and gaps, holds for an idle pipeline before subkey loads
   int burst_left = 0;
   int gap_left = 0;
   int hold_cnt = 0;
   always @(posedge clock) begin
      logic next_valid;
      cmd_type next_data;
      logic busy;
      pend_type head;
      next_valid = req_ch.valid;
      next_data = req_ch.data;
      busy = req_ch.valid && !req_ch.ready;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_ch.valid && req_ch.ready) begin
            if (req_ch.data.kind == KindBlock) begin
               cipher_q.push_back(encipher(req_ch.data.blk));
            end else if (req_ch.data.key_index < SubkeyCount) begin
               subkey_copy[req_ch.data.key_index] = req_ch.data.key_word;
            end
         end
         if (!busy) begin
            next_valid = 1'b0;
            if (pending_q.size() > 0 && pending_q[0].hold) begin
               if (cipher_q.size() == 0) hold_cnt++;
               if (hold_cnt > Latency + 6) begin
                  hold_cnt = 0;
                  void'(pending_q.pop_front());
               end
            end else if (gap_left > 0) begin
               gap_left--;
            end else if (pending_q.size() > 0) begin
               next_valid = 1'b1;
               head = pending_q.pop_front();
               next_data = head.cmd;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_ch.valid <= next_valid;
      req_ch.data <= next_data;
   end

   // receiver: rotates through four ready patterns, from always ready to ready one time in four
   always @(posedge clock) begin
      logic rdy;
      cycles++;
      case ((cycles >> 8) % 4)
         0: rdy = 1'b1;
         1: rdy = 1'($urandom_range(0, 1));
         2: rdy = ($urandom_range(0, 3) == 0);
         default: rdy = ($urandom_range(0, 7) != 0);
      endcase
      rsp_ch.ready <= reset ? 1'b0 : rdy;
      if (cycles > CycleLimit) begin
         $display("%0t timeout after %0d cycles", $realtime, cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // monitor: compare each result beat against the oldest prediction
   always @(posedge clock) begin
      block_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (cipher_q.size() == 0) begin
            errors++;
            $display("%0t unexpected result beat %h", $realtime, rsp_ch.data);
         end else begin
            want = cipher_q.pop_front();
            for (int i = 0; i < 4; i++) begin
               if (want[127-32*i -: 32] !== rsp_ch.data[127-32*i -: 32]) begin
                  errors++;
                  $display("%0t out%0d expected %h actual %h", $realtime, i,
                           want[127-32*i -: 32], rsp_ch.data[127-32*i -: 32]);
               end
            end
         end
      end
   end

   initial begin
      int wait_cnt;
      int mode;
      int n;
      // every subkey is written before any block beat
      for (int i = 0; i < SubkeyCount; i++) add_load(i, '0);
      add_block('0);
      add_block('1);
      add_block({32'hffffffff, 32'h0, 32'hffffffff, 32'h0});
      add_hold();
      for (int i = 0; i < SubkeyCount; i++) add_load(i, '1);
      add_load(61, $urandom);
      add_load(63, $urandom);
      add_block('0);
      add_block('1);
      add_block({4{32'haaaa_5555}});
      add_block({32'h8000_0000, 32'h7fff_ffff, 32'h1, 32'hffff_fffe});
      for (int ph = 0; ph < 9; ph++) begin
         add_hold();
         mode = (ph == 0) ? 0 : $urandom_range(0, 2);
         if (mode == 0) begin
            for (int i = 0; i < SubkeyCount; i++) add_load(i, $urandom);
         end else if (mode == 1) begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++) add_load($urandom_range(0, SubkeyCount - 1), rand_word());
         end else begin
            // rotate words at both extremes of their seven bits
            for (int r = 0; r <= RoundCount; r++)
               add_load(4 + 13 * r, {$urandom_range(0, 1) ? 25'h1ffffff : 25'h0,
                                    $urandom_range(0, 1) ? 7'h7f : 7'h00});
         end
         if ($urandom_range(0, 1)) add_load($urandom_range(SubkeyCount, 63), $urandom);
         for (int i = 0; i < 72; i++) add_block({rand_word(), rand_word(), rand_word(), rand_word()});
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      wait_cnt = 0;
      while (pending_q.size() > 0 || req_ch.valid || cipher_q.size() > 0) @(posedge clock);
      while (wait_cnt < 4 * Latency) begin
         @(posedge clock);
         wait_cnt++;
      end
      if (errors == 0 && cipher_q.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule
`default_nettype wire
